@@ design/length_framed_xor_deframer_core_macros.svh @@
// Assertion macros used by the deframer parser.
`ifndef LENGTH_FRAMED_XOR_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_FRAMED_XOR_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define LFXD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled while in reset.
`define LFXD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

@@ design/lfxd_pkg.sv @@
// Types and constants of the length-framed XOR deframer.
package lfxd_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;

   localparam logic [2:0] PH_SYNC1   = 3'd0;
   localparam logic [2:0] PH_SYNC2   = 3'd1;
   localparam logic [2:0] PH_LEN     = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_GOOD    = 2'd1;
   localparam logic [1:0] KIND_BAD     = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic [7:0] out_index;
      logic       out_last;
   } lfxd_result_type;

endpackage

@@ design/lfxd_parser.sv @@
// Frame receive state machine: phase, remaining count, running XOR and result decode.
`include "length_framed_xor_deframer_core_macros.svh"

module lfxd_parser
   import lfxd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output lfxd_result_type result
);

   logic [2:0] phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] position_ff, position_in;

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      xor_in       = xor_ff;
      position_in  = position_ff;
      result       = '0;
      result.out_byte = rx_byte;
      unique case (phase_ff)
         PH_SYNC2: begin
            phase_in = (rx_byte == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
         end
         PH_LEN: begin
            remaining_in = rx_byte;
            xor_in       = '0;
            position_in  = '0;
            phase_in     = (rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            result.valid     = 1'b1;
            result.out_kind  = KIND_PAYLOAD;
            result.out_index = position_ff;
            xor_in           = xor_ff ^ rx_byte;
            position_in      = position_ff + 8'd1;
            remaining_in     = remaining_ff - 8'd1;
            if (remaining_ff == 8'd1) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            result.valid    = 1'b1;
            result.out_kind = (rx_byte == xor_ff) ? KIND_GOOD : KIND_BAD;
            result.out_last = 1'b1;
            phase_in        = PH_SYNC1;
            xor_in          = '0;
            position_in     = '0;
            remaining_in    = '0;
         end
         default: begin
            xor_in      = '0;
            position_in = '0;
            phase_in    = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SYNC1;
         remaining_ff <= '0;
         xor_ff       <= '0;
         position_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         xor_ff       <= xor_in;
         position_ff  <= position_in;
      end
   end

   `LFXD_ASSERT_SAME(a_payload_count, clock, reset, phase_ff == PH_PAYLOAD, remaining_ff != 8'd0)
   `LFXD_ASSERT_SAME(a_last_is_status, clock, reset, result.valid && result.out_last,
                     result.out_kind != KIND_PAYLOAD)
   `LFXD_ASSERT_NEXT(a_final_payload, clock, reset,
                     step && phase_ff == PH_PAYLOAD && remaining_ff == 8'd1, phase_ff == PH_CHECK)
   `LFXD_ASSERT_NEXT(a_check_clears, clock, reset, step && phase_ff == PH_CHECK,
                     phase_ff == PH_SYNC1 && xor_ff == 8'd0 && position_ff == 8'd0)

endmodule

@@ design/lfxd_out_stage.sv @@
// Result register between the parser and the response channel.
module lfxd_out_stage
   import lfxd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  lfxd_result_type result,
   output logic            free,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [15:0]     rsp_tdata,  // out_byte [7:0], out_index [15:8]
   output logic [1:0]      rsp_tuser,  // out_kind [1:0]
   output logic            rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic [7:0] index_ff;
   logic       last_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= result.out_kind;
         byte_ff  <= result.out_byte;
         index_ff <= result.out_index;
         last_ff  <= result.out_last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {index_ff, byte_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ design/length_framed_xor_deframer_core.sv @@
// Length-framed XOR-checksum deframer, top level.
// Accepts one received byte per cycle while the response side keeps up, and hunts
// for frames of 0xFF, 0xFF, a length byte, that many payload bytes and an XOR
// checksum byte. Each payload byte comes out with its index (kind 0); the checksum
// byte closes the frame with kind 1 (good) or 2 (mismatch) and tlast set. Bytes
// outside a frame give no response. A request is taken every cycle while the
// response side keeps up; it is held in the input register and decoded on its way
// into the result register, which presents its response. Throughput is one byte
// per cycle while the response side keeps up.
module length_framed_xor_deframer_core
   import lfxd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // rx_byte [7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_byte [7:0], out_index [15:8]
   output logic [1:0]  rsp_tuser,   // out_kind [1:0]
   output logic        rsp_tlast
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_free;
   logic            advance;
   lfxd_result_type result;

   assign advance    = in_valid_ff && (!result.valid || out_free);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   lfxd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .result  (result)
   );

   lfxd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && result.valid),
      .result     (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
